### hdl/cri_pkg.sv
// shared constants and control types for the cubic rgba interpolator
`timescale 1ns / 1ps
package cri_pkg;

  // default number of fraction bits on the position input
  localparam int FRAC_BITS_DEF = 16;

  // register stages from input to output register
  localparam int NUM_STAGES = 6;

  // packed pixel layout
  localparam int PIX_LANES = 4;
  localparam int LANE_W    = 8;
  localparam int PIX_W     = PIX_LANES * LANE_W;

  // largest lane value after clamping
  localparam int BYTE_MAX = 255;

  // pipeline control toward the datapath and the ports
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic                  in_ready;
    logic                  out_valid;
  } cri_ctrl_t;

endpackage

### hdl/cri_samples_if.sv
// input channel: position and four neighbor pixels
`timescale 1ns / 1ps
interface cri_samples_if #(
  parameter int FRAC_BITS = cri_pkg::FRAC_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [FRAC_BITS:0]       frac_pos;
  logic [cri_pkg::PIX_W-1:0] pix_before;
  logic [cri_pkg::PIX_W-1:0] pix_left;
  logic [cri_pkg::PIX_W-1:0] pix_right;
  logic [cri_pkg::PIX_W-1:0] pix_after;

  modport source (
    output valid, frac_pos, pix_before, pix_left, pix_right, pix_after,
    input  ready
  );
  modport sink (
    input  valid, frac_pos, pix_before, pix_left, pix_right, pix_after,
    output ready
  );
endinterface

### hdl/cri_result_if.sv
// output channel: one interpolated packed pixel
`timescale 1ns / 1ps
interface cri_result_if;
  logic                      valid;
  logic                      ready;
  logic [cri_pkg::PIX_W-1:0] pix_out;

  modport source (
    output valid, pix_out,
    input  ready
  );
  modport sink (
    input  valid, pix_out,
    output ready
  );
endinterface

### hdl/cri_pipe_ctrl.sv
// valid bits and per-stage load enables with bubble collapse
`timescale 1ns / 1ps
module cri_pipe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_ready,
  output cri_pkg::cri_ctrl_t ctrl
);

  logic [cri_pkg::NUM_STAGES-1:0] stage_valid;
  logic [cri_pkg::NUM_STAGES-1:0] stage_ready;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    stage_ready[cri_pkg::NUM_STAGES-1] = !stage_valid[cri_pkg::NUM_STAGES-1] || out_ready;
    for (int k = cri_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < cri_pkg::NUM_STAGES; k++) begin
        if (stage_ready[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  always_comb begin
    ctrl.load      = stage_ready;
    ctrl.in_ready  = stage_ready[0];
    ctrl.out_valid = stage_valid[cri_pkg::NUM_STAGES-1];
  end

endmodule

### hdl/cri_lane.sv
// one byte lane: catmull-rom kernel in exact fixed point, six register stages
`timescale 1ns / 1ps
module cri_lane #(
  parameter int FRAC_BITS = cri_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic [cri_pkg::NUM_STAGES-1:0]   load,
  input  logic [3:0][FRAC_BITS:0]          frac,
  input  logic [cri_pkg::LANE_W-1:0]       c0,
  input  logic [cri_pkg::LANE_W-1:0]       c1,
  input  logic [cri_pkg::LANE_W-1:0]       c2,
  input  logic [cri_pkg::LANE_W-1:0]       c3,
  output logic [cri_pkg::LANE_W-1:0]       lane_out
);

  localparam int LW  = cri_pkg::LANE_W;
  localparam int HW  = FRAC_BITS + 13;       // a2*t + b2, scaled by 2^f
  localparam int PHW = FRAC_BITS + 14;       // 13-bit signed chunk times position
  localparam int PLW = 2 * FRAC_BITS + 1;    // f-bit chunk times position
  localparam int EW  = 2 * FRAC_BITS + 13;   // horner value scaled by 2^2f
  localparam int SW  = 3 * FRAC_BITS + 14;   // full numerator scaled by 2^3f
  localparam int RW  = SW - 3 * FRAC_BITS - 1;
  localparam logic signed [RW-1:0] R_MAX = RW'(cri_pkg::BYTE_MAX);

  // stage 0: doubled kernel coefficients
  logic signed [10:0] a2, a2_next;
  logic signed [11:0] b2, b2_next;
  logic signed [9:0]  cc2_s0, cc2_next;
  logic [LW:0]        k2_s0;

  // stage 1..5
  logic signed [HW-1:0]  h1, h1_next;
  logic signed [9:0]     cc2_s1, cc2_s2;
  logic [LW:0]           k2_s1, k2_s2, k2_s3, k2_s4;
  logic signed [PHW-1:0] phi, phi_next;
  logic [PLW-1:0]        plo, plo_next;
  logic signed [EW-1:0]  e2, e2_next;
  logic signed [PHW-1:0] qh, qh_next;
  logic [PLW-1:0]        qm, qm_next, ql, ql_next;
  logic signed [SW-1:0]  num;
  logic signed [RW-1:0]  res;
  logic [LW-1:0]         lane_next;

  logic signed [12:0]        hh;
  logic [FRAC_BITS-1:0]      hl;
  logic signed [12:0]        eh;
  logic [FRAC_BITS-1:0]      em, el;

  always_comb begin
    a2_next  = -$signed({3'b0, c0}) + 11'sd3 * $signed({3'b0, c1})
             - 11'sd3 * $signed({3'b0, c2}) + $signed({3'b0, c3});
    b2_next  = 12'sd2 * $signed({4'b0, c0}) - 12'sd5 * $signed({4'b0, c1})
             + 12'sd4 * $signed({4'b0, c2}) - $signed({4'b0, c3});
    cc2_next = $signed({2'b0, c2}) - $signed({2'b0, c0});
  end

  // h1 = a2*f + b2*2^f
  always_comb begin
    h1_next = HW'(a2) * HW'($signed({1'b0, frac[0]})) + (HW'(b2) <<< FRAC_BITS);
  end

  // split h1 so each product stays narrow
  always_comb begin
    hh       = h1[HW-1:FRAC_BITS];
    hl       = h1[FRAC_BITS-1:0];
    phi_next = PHW'(hh) * PHW'($signed({1'b0, frac[1]}));
    plo_next = PLW'(hl) * PLW'(frac[1]);
  end

  // e2 = h1*f + cc2*2^2f
  always_comb begin
    e2_next = (EW'(phi) <<< FRAC_BITS) + EW'($signed({1'b0, plo}))
            + (EW'(cc2_s2) <<< (2 * FRAC_BITS));
  end

  always_comb begin
    eh      = e2[EW-1:2*FRAC_BITS];
    em      = e2[2*FRAC_BITS-1:FRAC_BITS];
    el      = e2[FRAC_BITS-1:0];
    qh_next = PHW'(eh) * PHW'($signed({1'b0, frac[3]}));
    qm_next = PLW'(em) * PLW'(frac[3]);
    ql_next = PLW'(el) * PLW'(frac[3]);
  end

  // num = e2*f + (2*c1 + 1)*2^3f, lane value is floor(num / 2^(3f+1))
  always_comb begin
    num = (SW'(qh) <<< (2 * FRAC_BITS))
        + (SW'($signed({1'b0, qm})) <<< FRAC_BITS)
        + SW'($signed({1'b0, ql}))
        + (SW'($signed({1'b0, k2_s4})) <<< (3 * FRAC_BITS));
    res = num[SW-1:3*FRAC_BITS+1];
    if (res < 0) begin
      lane_next = '0;
    end else if (res > R_MAX) begin
      lane_next = LW'(cri_pkg::BYTE_MAX);
    end else begin
      lane_next = res[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      a2     <= a2_next;
      b2     <= b2_next;
      cc2_s0 <= cc2_next;
      k2_s0  <= {c1, 1'b1};
    end
    if (load[1]) begin
      h1     <= h1_next;
      cc2_s1 <= cc2_s0;
      k2_s1  <= k2_s0;
    end
    if (load[2]) begin
      phi    <= phi_next;
      plo    <= plo_next;
      cc2_s2 <= cc2_s1;
      k2_s2  <= k2_s1;
    end
    if (load[3]) begin
      e2    <= e2_next;
      k2_s3 <= k2_s2;
    end
    if (load[4]) begin
      qh    <= qh_next;
      qm    <= qm_next;
      ql    <= ql_next;
      k2_s4 <= k2_s3;
    end
    if (load[5]) begin
      lane_out <= lane_next;
    end
  end

endmodule

### hdl/cubic_rgba_interpolator_top.sv
// top level: catmull-rom interpolation of four packed rgba pixels
`timescale 1ns / 1ps
// usage
//   samples channel: frac_pos (position between pix_left and pix_right, FRAC_BITS
//   fraction bits, values above one count as one) and the four neighbor pixels
//   pix_before, pix_left, pix_right, pix_after
//   result channel: pix_out, each byte lane interpolated independently,
//   rounded half up and clamped to 0..255
//   every accepted item gives exactly one result item, in order
// throughput and stages
//   one item per cycle while result.ready stays high; the six register stages
//   are the coefficient setup, the first horner product, the split second
//   product, its recombination, the split third product, and the final add
//   with clamp
// reset
//   rst clears all valid bits; the pipeline is empty and samples.ready is high
// stalls
//   each stage loads when it is empty or its item moves on, so bubbles close up
//   and new items are still taken while a finished result waits in the output
//   register; nothing is dropped or repeated while result.ready is low
module cubic_rgba_interpolator_top #(
  parameter int FRAC_BITS = cri_pkg::FRAC_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  cri_samples_if.sink  samples,
  cri_result_if.source result
);

  localparam int LW = cri_pkg::LANE_W;
  localparam logic [FRAC_BITS:0] POS_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  cri_pkg::cri_ctrl_t ctrl;

  // position after saturation, then one copy for each of stages 0..3
  logic [FRAC_BITS:0]       frac_sat;
  logic [3:0][FRAC_BITS:0]  frac;
  logic [cri_pkg::PIX_LANES-1:0][LW-1:0] lane_res;

  cri_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .out_ready (result.ready),
    .ctrl      (ctrl)
  );

  always_comb begin
    frac_sat = (samples.frac_pos > POS_ONE) ? POS_ONE : samples.frac_pos;
  end

  // position rides along with stages 0..3
  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      frac[0] <= frac_sat;
    end
    for (int k = 1; k < 4; k++) begin
      if (ctrl.load[k]) begin
        frac[k] <= frac[k-1];
      end
    end
  end

  // the four byte lanes share control and position
  for (genvar g = 0; g < cri_pkg::PIX_LANES; g++) begin : g_lane
    cri_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .load     (ctrl.load),
      .frac     (frac),
      .c0       (samples.pix_before[g*LW +: LW]),
      .c1       (samples.pix_left[g*LW +: LW]),
      .c2       (samples.pix_right[g*LW +: LW]),
      .c3       (samples.pix_after[g*LW +: LW]),
      .lane_out (lane_res[g])
    );
  end

  assign samples.ready  = ctrl.in_ready;
  assign result.valid   = ctrl.out_valid;
  assign result.pix_out = lane_res;

endmodule

### hdl/cri_checker.sv
// port-level checks for the interpolator, bound to the top level
`timescale 1ns / 1ps
module cri_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [cri_pkg::PIX_W-1:0] pix_out
);

  localparam int OW = $clog2(cri_pkg::NUM_STAGES + 2);

  logic          in_acc, out_acc;
  logic [OW-1:0] occ, occ_next;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items accepted but not yet delivered
  always_comb begin
    case ({in_acc, out_acc})
      2'b10:   occ_next = occ + OW'(1);
      2'b01:   occ_next = occ - OW'(1);
      default: occ_next = occ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pix_out))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occ != '0)
    else $error("result without an item in flight");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(cri_pkg::NUM_STAGES))
    else $error("more items in flight than stages");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("not ready although output stage is empty");

endmodule

bind cubic_rgba_interpolator_top cri_checker u_cri_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .pix_out   (result.pix_out)
);

### sim/cubic_rgba_interpolator_top_tb.sv
// self-checking testbench for the catmull-rom rgba interpolator top level
`timescale 1ns / 1ps
module cubic_rgba_interpolator_top_tb;

  localparam int FRAC_BITS = cri_pkg::FRAC_BITS_DEF;
  // t = 1.0 in position units
  localparam longint ONE_POS = longint'(1) << FRAC_BITS;
  // largest value the position field can carry
  localparam int POS_MAX = (1 << (FRAC_BITS + 1)) - 1;

  // phase sizes; together with the directed cases 1130 input items
  localparam int RANDOM_ITEMS   = 850;
  localparam int DRAIN_ITEMS    = 40;
  localparam int HOLD_ITEMS     = 60;
  localparam int FULL_RATE_ITEMS = 160;

  // cycles the output side holds ready low during the backpressure test
  localparam int LONG_HOLD = 200;

  typedef struct packed {
    logic [FRAC_BITS:0]        frac_pos;
    logic [cri_pkg::PIX_W-1:0] pix_before;
    logic [cri_pkg::PIX_W-1:0] pix_left;
    logic [cri_pkg::PIX_W-1:0] pix_right;
    logic [cri_pkg::PIX_W-1:0] pix_after;
  } sample_t;

  logic clk = 1'b0;
  logic rst;

  cri_samples_if #(.FRAC_BITS(FRAC_BITS)) samples_ch ();
  cri_result_if                           result_ch ();

  cubic_rgba_interpolator_top #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_ch),
    .result (result_ch)
  );

  // expected interpolated pixels, oldest first
  logic [cri_pkg::PIX_W-1:0] expected_pix_q[$];
  int                        error_count = 0;

  // idling controls shared between the stimulus and the output side
  bit tx_gaps       = 1'b0;
  bit rx_stalls     = 1'b0;
  bit long_hold_req = 1'b0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // catmull-rom per byte lane, evaluated exactly over the common
  // denominator 2*S^3 (S = one position unit); an arithmetic shift gives
  // the floor of (poly + 1/2) directly, then clamp to one byte
  function automatic logic [cri_pkg::PIX_W-1:0] interpolate_pixel(input sample_t s);
    longint                    f;
    longint                    c0, c1, c2, c3;
    longint                    a2, b2, cc2, k2;
    longint                    num, lane_val;
    logic [cri_pkg::PIX_W-1:0] pix;
    pix = '0;
    f   = longint'(s.frac_pos);
    // positions above one saturate to one
    if (f > ONE_POS) f = ONE_POS;
    for (int lane = 0; lane < cri_pkg::PIX_LANES; lane++) begin
      c0 = longint'(s.pix_before[lane*cri_pkg::LANE_W +: cri_pkg::LANE_W]);
      c1 = longint'(s.pix_left[lane*cri_pkg::LANE_W +: cri_pkg::LANE_W]);
      c2 = longint'(s.pix_right[lane*cri_pkg::LANE_W +: cri_pkg::LANE_W]);
      c3 = longint'(s.pix_after[lane*cri_pkg::LANE_W +: cri_pkg::LANE_W]);
      // doubled coefficients of the cubic, rounding half folded into k2
      a2  = 3 * (c1 - c2) + c3 - c0;
      b2  = 2 * c0 - 5 * c1 + 4 * c2 - c3;
      cc2 = c2 - c0;
      k2  = 2 * c1 + 1;
      // horner form scaled by S^3; magnitude stays below 2^60
      num = ((a2 * f + b2 * ONE_POS) * f + cc2 * ONE_POS * ONE_POS) * f
            + k2 * ONE_POS * ONE_POS * ONE_POS;
      lane_val = num >>> (3 * FRAC_BITS + 1);
      if (lane_val < 0)
        pix[lane*cri_pkg::LANE_W +: cri_pkg::LANE_W] = '0;
      else if (lane_val > cri_pkg::BYTE_MAX)
        pix[lane*cri_pkg::LANE_W +: cri_pkg::LANE_W] = cri_pkg::LANE_W'(cri_pkg::BYTE_MAX);
      else
        pix[lane*cri_pkg::LANE_W +: cri_pkg::LANE_W] = lane_val[cri_pkg::LANE_W-1:0];
    end
    return pix;
  endfunction

  // pixels that hit the interesting byte values often, otherwise fully random
  function automatic logic [cri_pkg::PIX_W-1:0] rand_pixel();
    logic [cri_pkg::PIX_W-1:0] pix;
    pix = $urandom();
    if ($urandom_range(0, 1) == 0) begin
      for (int lane = 0; lane < cri_pkg::PIX_LANES; lane++) begin
        case ($urandom_range(0, 3))
          0: pix[lane*cri_pkg::LANE_W +: cri_pkg::LANE_W] = '0;
          1: pix[lane*cri_pkg::LANE_W +: cri_pkg::LANE_W] =
               cri_pkg::LANE_W'(cri_pkg::BYTE_MAX);
          default: pix[lane*cri_pkg::LANE_W +: cri_pkg::LANE_W] =
               cri_pkg::LANE_W'($urandom());
        endcase
      end
    end
    return pix;
  endfunction

  // positions: mostly inside 0..1, with the ends and saturation mixed in
  function automatic logic [FRAC_BITS:0] rand_frac();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return (FRAC_BITS+1)'(ONE_POS);
      2: return (FRAC_BITS+1)'($urandom_range(ONE_POS + 1, POS_MAX));
      3: return (FRAC_BITS+1)'($urandom_range(0, 15));
      default: return (FRAC_BITS+1)'($urandom_range(0, ONE_POS));
    endcase
  endfunction

  // offer one item and return at the edge where it is taken; valid stays
  // high afterwards so back-to-back calls stream at full rate
  task automatic send_item(input logic [FRAC_BITS:0] frac,
                           input logic [cri_pkg::PIX_W-1:0] prior, left, right, after);
    sample_t s;
    s.frac_pos   = frac;
    s.pix_before = prior;
    s.pix_left   = left;
    s.pix_right  = right;
    s.pix_after  = after;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      samples_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    samples_ch.valid      <= 1'b1;
    samples_ch.frac_pos   <= s.frac_pos;
    samples_ch.pix_before <= s.pix_before;
    samples_ch.pix_left   <= s.pix_left;
    samples_ch.pix_right  <= s.pix_right;
    samples_ch.pix_after  <= s.pix_after;
    // ready is settled by the falling edge; the item moves on the next rise
    do @(negedge clk); while (samples_ch.ready !== 1'b1);
    @(posedge clk);
    expected_pix_q.push_back(interpolate_pixel(s));
  endtask

  // stop offering items until every expected pixel has come out
  task automatic wait_results();
    samples_ch.valid <= 1'b0;
    while (expected_pix_q.size() != 0) @(posedge clk);
    repeat (cri_pkg::NUM_STAGES + 2) @(posedge clk);
  endtask

  // ends of the position range, saturation, clamping on both sides,
  // mixed lanes and rounding at one half
  task automatic test_directed_cases();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_item('0, 32'h0102_0304, 32'h1122_3344, 32'h5566_7788, 32'h99AA_BBCC);
    send_item((FRAC_BITS+1)'(ONE_POS), 32'h0102_0304, 32'h1122_3344,
              32'h5566_7788, 32'h99AA_BBCC);
    send_item((FRAC_BITS+1)'(ONE_POS + 1), 32'hFFFF_FFFF, 32'h0000_0000,
              32'hA5A5_A5A5, 32'h0000_0000);
    send_item((FRAC_BITS+1)'(POS_MAX), 32'h0000_0000, 32'hFFFF_FFFF,
              32'h5A5A_5A5A, 32'hFFFF_FFFF);
    send_item(17'h0AAAA, '0, '0, '0, '0);
    send_item(17'h15555, '1, '1, '1, '1);
    send_item(17'h08000, '0, '0, '0, '0);
    send_item(17'h08000, '1, '1, '1, '1);
    // dip between two bright neighbors: undershoot clamps to zero
    send_item(17'h08000, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF);
    send_item(17'h04000, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF);
    // plateau between dark neighbors: overshoot clamps to 255
    send_item(17'h08000, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_item(17'h0C000, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    // step edge, each lane its own shape
    send_item(17'h04000, 32'h00FF_00FF, 32'h00FF_00FF, 32'hFF00_FF00, 32'hFF00_FF00);
    send_item(17'h0C000, 32'hFF00_00FF, 32'h00FF_FF00, 32'hFF00_00FF, 32'h00FF_FF00);
    // smallest and largest step inside the interval
    send_item(17'h00001, 32'h0000_00FF, 32'hFF00_0080, 32'h00FF_8000, 32'hFFFF_FFFF);
    send_item(17'h0FFFF, 32'h0000_00FF, 32'hFF00_0080, 32'h00FF_8000, 32'hFFFF_FFFF);
    // results that land on one half, then both ends of the interval
    send_item(17'h08000, 32'h0001_0203, 32'h0001_0203, 32'h0102_0304, 32'h0102_0304);
    send_item(17'h08000, 32'h7F80_FEFF, 32'h7F80_FEFF, 32'h8081_FFFE, 32'h8081_FFFE);
    send_item(17'h10000, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 32'h8765_4321);
    send_item(17'h00000, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 32'h8765_4321);
    wait_results();
  endtask

  // bulk random items with idling on both sides
  task automatic test_random_items();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    repeat (RANDOM_ITEMS)
      send_item(rand_frac(), rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
  endtask

  // sender goes quiet until the pipeline has fully drained, then resumes
  task automatic test_drain_pause();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    repeat (DRAIN_ITEMS / 2)
      send_item(rand_frac(), rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    wait_results();
    repeat (DRAIN_ITEMS / 2)
      send_item(rand_frac(), rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
  endtask

  // output held off for a long stretch while items keep coming, so the
  // pipeline fills and must push back on the input
  task automatic test_output_hold();
    tx_gaps       = 1'b0;
    long_hold_req = 1'b1;
    repeat (HOLD_ITEMS)
      send_item(rand_frac(), rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    wait_results();
  endtask

  // last stretch at full rate with no idling on either side
  task automatic test_full_rate();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    repeat (FULL_RATE_ITEMS)
      send_item(rand_frac(), rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    wait_results();
  endtask

  // output side: ready driven at the rising edge, with random stall bursts
  // or one long hold on request
  initial begin
    result_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        result_ch.ready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // result check: a pixel accepted at the next rising edge is compared
  // against the oldest expectation
  initial begin : result_check
    logic [cri_pkg::PIX_W-1:0] want_pix;
    forever begin
      @(negedge clk);
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        if (expected_pix_q.size() == 0) begin
          $error("pix_out item with nothing expected: actual %h", result_ch.pix_out);
          error_count++;
        end else begin
          want_pix = expected_pix_q.pop_front();
          if (result_ch.pix_out !== want_pix) begin
            $error("pix_out mismatch: expected %h, actual %h", want_pix, result_ch.pix_out);
            error_count++;
          end
        end
      end
    end
  end

  // main sequence
  initial begin
    rst                   <= 1'b1;
    samples_ch.valid      <= 1'b0;
    samples_ch.frac_pos   <= '0;
    samples_ch.pix_before <= '0;
    samples_ch.pix_left   <= '0;
    samples_ch.pix_right  <= '0;
    samples_ch.pix_after  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_items();
    test_drain_pause();
    test_output_hold();
    test_full_rate();

    if (error_count == 0) begin
      $display("cubic_rgba_interpolator_top_tb passed");
    end else begin
      $display("cubic_rgba_interpolator_top_tb failed");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #600000;
    $display("cubic_rgba_interpolator_top_tb failed");
    $finish;
  end

endmodule

### sim.f
hdl/cri_pkg.sv
hdl/cri_samples_if.sv
hdl/cri_result_if.sv
hdl/cri_pipe_ctrl.sv
hdl/cri_lane.sv
hdl/cubic_rgba_interpolator_top.sv
hdl/cri_checker.sv
sim/cubic_rgba_interpolator_top_tb.sv
